// ----- src/hisu_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hisu_pkg
// Types and constants shared by the homography inlier scorer.
// ---------------------------------------------------------------------------
package hisu_pkg;

    localparam int ACC_W   = 66;   // accumulator, signed
    localparam int MA_W    = 44;   // multiplier operand a, signed
    localparam int MB_W    = 18;   // multiplier operand b, signed
    localparam int MP_W    = 62;   // product, signed
    localparam int ADJ_W   = 43;   // stored adjugate entry, signed
    localparam int Q_W     = 35;   // projected coordinate, signed Q.16
    localparam int SCORE_W = 36;
    localparam int CHI_W   = 19;

    localparam logic [CHI_W-1:0]   CHI_THR   = 19'd392626;  // 5.991 in Q.16
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [5:0]         SHIFT_MAX = 6'd21;

    localparam logic [63:0] RST_PAIR0 = 64'd4503599628419072;
    localparam logic [63:0] RST_PAIR1 = 64'd0;
    localparam logic [63:0] RST_PAIR2 = 64'd1048576;
    localparam logic [63:0] RST_PAIR3 = 64'd0;
    localparam logic [31:0] RST_LAST  = 32'd1048576;
    localparam logic [23:0] RST_INV   = 24'd65536;

    localparam logic [2:0] REG_PAIR0 = 3'd0;
    localparam logic [2:0] REG_PAIR1 = 3'd1;
    localparam logic [2:0] REG_PAIR2 = 3'd2;
    localparam logic [2:0] REG_PAIR3 = 3'd3;
    localparam logic [2:0] REG_LAST  = 3'd4;
    localparam logic [2:0] REG_INV   = 3'd5;

    typedef struct packed {
        logic valid;
        logic clr;
        logic sub;
        logic shl;
        logic shr;
    } mac_ctl_t;

    // cofactor i = h[p]*h[q] - h[r]*h[s], packed {p,q,r,s}
    function automatic logic [15:0] cof_idx(input logic [3:0] i);
        logic [15:0] r;
        r = 16'h0;
        unique case (i)
            4'd0:    r = {4'd4, 4'd8, 4'd5, 4'd7};
            4'd1:    r = {4'd2, 4'd7, 4'd1, 4'd8};
            4'd2:    r = {4'd1, 4'd5, 4'd2, 4'd4};
            4'd3:    r = {4'd5, 4'd6, 4'd3, 4'd8};
            4'd4:    r = {4'd0, 4'd8, 4'd2, 4'd6};
            4'd5:    r = {4'd2, 4'd3, 4'd0, 4'd5};
            4'd6:    r = {4'd3, 4'd7, 4'd4, 4'd6};
            4'd7:    r = {4'd1, 4'd6, 4'd0, 4'd7};
            4'd8:    r = {4'd0, 4'd4, 4'd1, 4'd3};
            default: r = 16'h0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/hisu_mac.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hisu_mac
// Shared signed multiplier with registered product and accumulator.
// ---------------------------------------------------------------------------
module hisu_mac (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic signed [hisu_pkg::MA_W-1:0]  op_a,
    input  wire logic signed [hisu_pkg::MB_W-1:0]  op_b,
    input  wire hisu_pkg::mac_ctl_t                ctl,
    output logic signed [hisu_pkg::ACC_W-1:0]      acc
);

    logic signed [hisu_pkg::MP_W-1:0]  prod_reg;
    logic signed [hisu_pkg::MP_W-1:0]  prod_next;
    hisu_pkg::mac_ctl_t                ctl_reg;
    logic signed [hisu_pkg::ACC_W-1:0] acc_reg;
    logic signed [hisu_pkg::ACC_W-1:0] acc_next;
    logic signed [hisu_pkg::ACC_W-1:0] base;
    logic signed [hisu_pkg::ACC_W-1:0] term;

    assign prod_next = op_a * op_b;

    always_comb begin
        term = {{(hisu_pkg::ACC_W - hisu_pkg::MP_W){prod_reg[hisu_pkg::MP_W-1]}}, prod_reg};
        if (ctl_reg.shl) begin
            term = term <<< 16;
        end
        if (ctl_reg.clr) begin
            base = '0;
        end else if (ctl_reg.shr) begin
            base = acc_reg >>> 16;
        end else begin
            base = acc_reg;
        end
        acc_next = ctl_reg.sub ? base - term : base + term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl;
        end
        prod_reg <= prod_next;
        if (ctl_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

// ----- src/hisu_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// hisu_div
// Restoring divider: num/den in Q.16, truncated, magnitude capped at 2^33.
// ---------------------------------------------------------------------------
module hisu_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic signed [hisu_pkg::ACC_W-1:0] num,
    input  wire logic signed [hisu_pkg::ACC_W-1:0] den,
    output logic                                   done,
    output logic signed [hisu_pkg::Q_W-1:0]        quot
);

    logic [77:0]                    d_reg;
    logic [94:0]                    v_reg;
    logic [33:0]                    q_reg;
    logic [5:0]                     cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic                           neg_reg;
    logic [hisu_pkg::ACC_W-1:0]     un;
    logic [hisu_pkg::ACC_W-1:0]     ud;
    logic                           ge;
    logic [33:0]                    mag;

    assign un  = num[hisu_pkg::ACC_W-1] ? -num : num;
    assign ud  = den[hisu_pkg::ACC_W-1] ? -den : den;
    assign ge  = {17'b0, d_reg} >= v_reg;
    assign mag = q_reg[33] ? 34'h2_0000_0000 : q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                d_reg    <= {un[61:0], 16'b0};
                v_reg    <= {ud[61:0], 33'b0};
                q_reg    <= '0;
                neg_reg  <= num[hisu_pkg::ACC_W-1] ^ den[hisu_pkg::ACC_W-1];
                cnt_reg  <= 6'd34;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (ge) begin
                    d_reg <= d_reg - v_reg[77:0];
                end
                q_reg   <= {q_reg[32:0], ge};
                v_reg   <= v_reg >> 1;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule
`default_nettype wire

// ----- src/homography_inlier_scorer_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// homography_inlier_scorer_unit
// Symmetric transfer error test of point matches against a homography.
// ---------------------------------------------------------------------------
// One match runs the forward transfer test and, if it passes, the backward
// test, then hands over the result. Each test does two 34-step divisions and
// 17 multiply-accumulate operations on the single shared multiplier.
// After reset and after every write to registers 0 to 5 the adjugate is
// rebuilt on the same multiplier (38 cofactor steps, up to 22 scale search
// steps, 9 normalize steps); no beat is accepted meanwhile.
module homography_inlier_scorer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // x1, y1, x2, y2
    input  wire logic [0:0]  s_tuser,   // first_of_set
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // score_total, zero pad
    output logic [1:0]       m_tuser,   // inlier, degenerate
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    typedef enum logic [3:0] {
        S_COF, S_SRCH, S_NORM, S_IDLE, S_W, S_WCHK, S_NU, S_DU,
        S_NV, S_DV, S_DIFF, S_SQ, S_CHI, S_DEC, S_OUT
    } state_t;

    function automatic logic [31:0] hsel(input logic [3:0] k,
                                         input logic [63:0] c0, input logic [63:0] c1,
                                         input logic [63:0] c2, input logic [63:0] c3,
                                         input logic [31:0] c4);
        logic [31:0] r;
        r = 32'h0;
        unique case (k)
            4'd0:    r = c0[31:0];
            4'd1:    r = c0[63:32];
            4'd2:    r = c1[31:0];
            4'd3:    r = c1[63:32];
            4'd4:    r = c2[31:0];
            4'd5:    r = c2[63:32];
            4'd6:    r = c3[31:0];
            4'd7:    r = c3[63:32];
            4'd8:    r = c4;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic [30:0] sat_abs(input logic signed [hisu_pkg::Q_W-1:0] p,
                                            input logic [15:0] ref_pt);
        logic signed [35:0] d;
        logic [30:0]        r;
        d = $signed({p[hisu_pkg::Q_W-1], p}) - $signed({8'b0, ref_pt, 12'b0});
        if (d > 36'sh0_7FFF_FFFF || d < -36'sh0_7FFF_FFFF) begin
            r = 31'h7FFF_FFFF;
        end else if (d < 0) begin
            r = 31'(-d);
        end else begin
            r = d[30:0];
        end
        return r;
    endfunction

    state_t                             state_reg;
    logic [5:0]                         step_reg;
    logic [63:0]                        pair0_reg, pair1_reg, pair2_reg, pair3_reg;
    logic [31:0]                        last_reg;
    logic [23:0]                        inv_reg;
    logic [hisu_pkg::ACC_W-1:0]         adj_mem [0:8];
    logic [hisu_pkg::ACC_W-1:0]         or_reg;
    logic [5:0]                         sh_reg;
    logic [15:0]                        x1_reg, y1_reg, x2_reg, y2_reg;
    logic                               pass_reg;
    logic                               inl_reg;
    logic                               deg_reg;
    logic [hisu_pkg::SCORE_W-1:0]       score_reg;
    logic signed [hisu_pkg::ACC_W-1:0]  w_reg;
    logic signed [hisu_pkg::Q_W-1:0]    px_reg, py_reg;
    logic [30:0]                        ax_reg, ay_reg;
    logic [62:0]                        d2_reg;
    logic                               m_valid_reg;
    logic [hisu_pkg::SCORE_W-1:0]       m_score_reg;
    logic                               m_inl_reg, m_deg_reg;

    logic signed [hisu_pkg::MA_W-1:0]   mac_a;
    logic signed [hisu_pkg::MB_W-1:0]   mac_b;
    hisu_pkg::mac_ctl_t                 mac_ctl;
    logic signed [hisu_pkg::ACC_W-1:0]  acc;
    logic                               div_start;
    logic                               div_done;
    logic signed [hisu_pkg::Q_W-1:0]    div_q;

    logic [15:0]                        cidx;
    logic [3:0]                         hk_a, hk_b;
    logic [31:0]                        h_a, h_b;
    logic [3:0]                         pk;
    logic [3:0]                         adj_idx;
    logic [hisu_pkg::ACC_W-1:0]         adj_rd;
    logic [15:0]                        sx, sy, dx, dy;
    logic [30:0]                        sq_a;
    logic [5:0]                         cj;
    logic [15:0]                        d2_piece;
    logic signed [hisu_pkg::ACC_W-1:0]  norm_val;
    logic [36:0]                        score_sum;
    logic                               chi_pass;
    logic                               s_acc, cfg_acc;

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign sx = pass_reg ? x2_reg : x1_reg;
    assign sy = pass_reg ? y2_reg : y1_reg;
    assign dx = pass_reg ? x1_reg : x2_reg;
    assign dy = pass_reg ? y1_reg : y2_reg;

    assign cidx = hisu_pkg::cof_idx(step_reg[5:2]);
    assign hk_a = step_reg[1] ? cidx[7:4] : cidx[15:12];
    assign hk_b = step_reg[1] ? cidx[3:0] : cidx[11:8];
    assign h_a  = hsel(hk_a, pair0_reg, pair1_reg, pair2_reg, pair3_reg, last_reg);
    assign h_b  = hsel(hk_b, pair0_reg, pair1_reg, pair2_reg, pair3_reg, last_reg);

    always_comb begin
        unique case (state_reg)
            S_W:     pk = 4'd6 + step_reg[3:0];
            S_NV:    pk = 4'd3 + step_reg[3:0];
            default: pk = step_reg[3:0];
        endcase
    end

    assign adj_idx  = (pk > 4'd8) ? 4'd8 : pk;
    assign adj_rd   = adj_mem[adj_idx];
    assign sq_a     = step_reg[1] ? ay_reg : ax_reg;
    assign cj       = step_reg - 6'd1;
    assign norm_val = $signed(adj_mem[adj_idx]) >>> sh_reg;
    assign chi_pass = (acc[hisu_pkg::ACC_W-1:hisu_pkg::CHI_W] == '0)
                      && (acc[hisu_pkg::CHI_W-1:0] <= hisu_pkg::CHI_THR);
    assign score_sum = {1'b0, score_reg}
                       + 37'(hisu_pkg::CHI_THR - acc[hisu_pkg::CHI_W-1:0]);

    always_comb begin
        unique case (cj[1:0])
            2'd0:    d2_piece = d2_reg[15:0];
            2'd1:    d2_piece = d2_reg[31:16];
            2'd2:    d2_piece = d2_reg[47:32];
            default: d2_piece = {1'b0, d2_reg[62:48]};
        endcase
    end

    always_comb begin
        mac_a   = '0;
        mac_b   = '0;
        mac_ctl = '0;
        unique case (state_reg)
            S_COF: begin
                mac_a = {{(hisu_pkg::MA_W-32){h_a[31]}}, h_a};
                mac_b = step_reg[0] ? {{2{h_b[31]}}, h_b[31:16]} : {2'b0, h_b[15:0]};
                mac_ctl.valid = (step_reg < 6'd36);
                mac_ctl.clr   = (step_reg[1:0] == 2'd0);
                mac_ctl.shl   = step_reg[0];
                mac_ctl.sub   = step_reg[1];
            end
            S_W, S_NU, S_NV: begin
                mac_a = pass_reg ? adj_rd[hisu_pkg::MA_W-1:0]
                                 : {{(hisu_pkg::MA_W-32){h_pk_sign()}}, h_pk()};
                unique case (step_reg[1:0])
                    2'd0:    mac_b = {2'b0, sx};
                    2'd1:    mac_b = {2'b0, sy};
                    default: mac_b = 18'sd16;
                endcase
                mac_ctl.valid = (step_reg < 6'd3);
                mac_ctl.clr   = (step_reg == 6'd0);
            end
            S_SQ: begin
                mac_a = {13'b0, sq_a};
                mac_b = step_reg[0] ? {3'b0, sq_a[30:16]} : {2'b0, sq_a[15:0]};
                mac_ctl.valid = (step_reg < 6'd4);
                mac_ctl.clr   = (step_reg == 6'd0);
                mac_ctl.shl   = step_reg[0];
            end
            S_CHI: begin
                mac_a = {20'b0, inv_reg};
                mac_b = {2'b0, d2_piece};
                mac_ctl.valid = (step_reg >= 6'd1) && (step_reg <= 6'd4);
                mac_ctl.clr   = (cj == 6'd0);
                mac_ctl.shr   = (cj == 6'd1) || (cj == 6'd2);
                mac_ctl.shl   = (cj == 6'd3);
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    function automatic logic [31:0] h_pk();
        return hsel(pk, pair0_reg, pair1_reg, pair2_reg, pair3_reg, last_reg);
    endfunction

    function automatic logic h_pk_sign();
        logic [31:0] v;
        v = hsel(pk, pair0_reg, pair1_reg, pair2_reg, pair3_reg, last_reg);
        return v[31];
    endfunction

    assign div_start = ((state_reg == S_DU) || (state_reg == S_DV)) && (step_reg == 6'd0);

    hisu_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .ctl     (mac_ctl),
        .acc     (acc)
    );

    hisu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc),
        .den     (w_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_COF;
            step_reg    <= '0;
            or_reg      <= '0;
            sh_reg      <= '0;
            pair0_reg   <= hisu_pkg::RST_PAIR0;
            pair1_reg   <= hisu_pkg::RST_PAIR1;
            pair2_reg   <= hisu_pkg::RST_PAIR2;
            pair3_reg   <= hisu_pkg::RST_PAIR3;
            last_reg    <= hisu_pkg::RST_LAST;
            inv_reg     <= hisu_pkg::RST_INV;
            score_reg   <= '0;
            pass_reg    <= 1'b0;
            inl_reg     <= 1'b0;
            deg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_COF: begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg >= 6'd5 && step_reg[1:0] == 2'd1) begin
                        adj_mem[4'((step_reg - 6'd5) >> 2)] <= acc;
                        or_reg <= or_reg | (acc ^ {hisu_pkg::ACC_W{acc[hisu_pkg::ACC_W-1]}});
                    end
                    if (step_reg == 6'd37) begin
                        state_reg <= S_SRCH;
                        sh_reg    <= '0;
                    end
                end
                S_SRCH: begin
                    if ((or_reg >> (7'd42 + 7'(sh_reg))) == '0 || sh_reg == hisu_pkg::SHIFT_MAX) begin
                        state_reg <= S_NORM;
                        step_reg  <= '0;
                    end else begin
                        sh_reg <= sh_reg + 6'd1;
                    end
                end
                S_NORM: begin
                    adj_mem[adj_idx] <= {{(hisu_pkg::ACC_W-hisu_pkg::ADJ_W){norm_val[hisu_pkg::ADJ_W-1]}},
                                         norm_val[hisu_pkg::ADJ_W-1:0]};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd8) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    step_reg <= '0;
                    if (cfg_acc) begin
                        priority case (cfg_index)
                            hisu_pkg::REG_PAIR0: pair0_reg <= cfg_data;
                            hisu_pkg::REG_PAIR1: pair1_reg <= cfg_data;
                            hisu_pkg::REG_PAIR2: pair2_reg <= cfg_data;
                            hisu_pkg::REG_PAIR3: pair3_reg <= cfg_data;
                            hisu_pkg::REG_LAST:  last_reg  <= cfg_data[31:0];
                            hisu_pkg::REG_INV:   inv_reg   <= cfg_data[23:0];
                            default: ;
                        endcase
                        if (cfg_index <= hisu_pkg::REG_INV) begin
                            state_reg <= S_COF;
                            or_reg    <= '0;
                        end
                    end else if (s_acc) begin
                        x1_reg    <= s_tdata[15:0];
                        y1_reg    <= s_tdata[31:16];
                        x2_reg    <= s_tdata[47:32];
                        y2_reg    <= s_tdata[63:48];
                        if (s_tuser[0]) begin
                            score_reg <= '0;
                        end
                        pass_reg  <= 1'b0;
                        inl_reg   <= 1'b0;
                        deg_reg   <= 1'b0;
                        state_reg <= S_W;
                    end
                end
                S_W: begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd3) begin
                        state_reg <= S_WCHK;
                    end
                end
                S_WCHK: begin
                    w_reg    <= acc;
                    step_reg <= '0;
                    if (acc == '0) begin
                        deg_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_NU;
                    end
                end
                S_NU, S_NV: begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd3) begin
                        step_reg  <= '0;
                        state_reg <= (state_reg == S_NU) ? S_DU : S_DV;
                    end
                end
                S_DU, S_DV: begin
                    step_reg <= 6'd1;
                    if (div_done) begin
                        step_reg <= '0;
                        if (state_reg == S_DU) begin
                            px_reg    <= div_q;
                            state_reg <= S_NV;
                        end else begin
                            py_reg    <= div_q;
                            state_reg <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    ax_reg    <= sat_abs(px_reg, dx);
                    ay_reg    <= sat_abs(py_reg, dy);
                    step_reg  <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ: begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd4) begin
                        step_reg  <= '0;
                        state_reg <= S_CHI;
                    end
                end
                S_CHI: begin
                    if (step_reg == 6'd0) begin
                        d2_reg <= acc[62:0];
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd5) begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    step_reg <= '0;
                    if (chi_pass) begin
                        score_reg <= score_sum[36] ? hisu_pkg::SCORE_MAX : score_sum[35:0];
                        if (!pass_reg) begin
                            pass_reg  <= 1'b1;
                            state_reg <= S_W;
                        end else begin
                            inl_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_score_reg <= score_reg;
                        m_inl_reg   <= inl_reg;
                        m_deg_reg   <= deg_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_score_reg};
    assign m_tuser  = {m_deg_reg, m_inl_reg};

`ifndef SYNTHESIS
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sh_reg <= hisu_pkg::SHIFT_MAX)
        else $error("adjugate shift out of range");
    a_out_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("inlier and degenerate both set");
    a_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DU || state_reg == S_DV))
        else $error("division finished outside a wait state");
    a_zero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DU && step_reg == 6'd0) |-> (w_reg != '0))
        else $error("division started with zero denominator");
`endif

endmodule
`default_nettype wire

// ----- dv/hisu_checker.sv -----
// ---------------------------------------------------------------------------
// hisu_checker
// Watches the match, result and register channels of the homography inlier
// scorer, predicts every result beat from its own copy of the registers and
// running score, and compares field by field in order.
// ---------------------------------------------------------------------------
module hisu_checker
    import hisu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic [0:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output int               errors,
    output int               pending,
    output int               n_results,
    output int               n_inlier,
    output int               n_degen
);

    typedef logic signed [127:0] wide_t;

    typedef enum int {XF_PASS, XF_FAIL, XF_DEGEN} xfer_t;

    typedef struct packed {
        logic               inlier;
        logic               degen;
        logic [SCORE_W-1:0] score;
    } verdict_t;

    localparam wide_t ADJ_LIM  = wide_t'(1) <<< 42;
    localparam wide_t DIFF_LIM = wide_t'(32'h7fff_ffff);
    localparam wide_t QSAT     = wide_t'(1) <<< 33;

    logic [63:0]        hreg [6];
    wide_t              hmat [9];
    wide_t              adjm [9];
    logic [SCORE_W-1:0] score_acc;
    verdict_t           expected_q [$];

    initial begin
        errors    = 0;
        pending   = 0;
        n_results = 0;
        n_inlier  = 0;
        n_degen   = 0;
    end

    function automatic wide_t sx32(input logic [31:0] v);
        return wide_t'(signed'(v));
    endfunction

    function automatic void rebuild_adjugate();
        wide_t c [9];
        wide_t t;
        int    s;
        bit    fits;
        hmat[0] = sx32(hreg[0][31:0]);  hmat[1] = sx32(hreg[0][63:32]);
        hmat[2] = sx32(hreg[1][31:0]);  hmat[3] = sx32(hreg[1][63:32]);
        hmat[4] = sx32(hreg[2][31:0]);  hmat[5] = sx32(hreg[2][63:32]);
        hmat[6] = sx32(hreg[3][31:0]);  hmat[7] = sx32(hreg[3][63:32]);
        hmat[8] = sx32(hreg[4][31:0]);
        c[0] = hmat[4] * hmat[8] - hmat[5] * hmat[7];
        c[1] = hmat[2] * hmat[7] - hmat[1] * hmat[8];
        c[2] = hmat[1] * hmat[5] - hmat[2] * hmat[4];
        c[3] = hmat[5] * hmat[6] - hmat[3] * hmat[8];
        c[4] = hmat[0] * hmat[8] - hmat[2] * hmat[6];
        c[5] = hmat[2] * hmat[3] - hmat[0] * hmat[5];
        c[6] = hmat[3] * hmat[7] - hmat[4] * hmat[6];
        c[7] = hmat[1] * hmat[6] - hmat[0] * hmat[7];
        c[8] = hmat[0] * hmat[4] - hmat[1] * hmat[3];
        // smallest common floor shift that brings all nine into 43 bits, capped at 21
        for (s = 0; s < 21; s++) begin
            fits = 1'b1;
            for (int i = 0; i < 9; i++) begin
                t = c[i] >>> s;
                if (t < -ADJ_LIM || t > ADJ_LIM - 1)
                    fits = 1'b0;
            end
            if (fits)
                break;
        end
        for (int i = 0; i < 9; i++)
            adjm[i] = c[i] >>> s;
    endfunction

    function automatic void load_defaults();
        hreg[REG_PAIR0] = RST_PAIR0;
        hreg[REG_PAIR1] = RST_PAIR1;
        hreg[REG_PAIR2] = RST_PAIR2;
        hreg[REG_PAIR3] = RST_PAIR3;
        hreg[REG_LAST]  = 64'(RST_LAST);
        hreg[REG_INV]   = 64'(RST_INV);
        rebuild_adjugate();
    endfunction

    // Q.16 quotient, truncated toward zero, magnitude clamped at 2^33
    function automatic wide_t quot_q16(input wide_t num, input wide_t den);
        wide_t un;
        wide_t ud;
        wide_t mag;
        bit    neg;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        if (un / ud >= (wide_t'(1) <<< 17))
            mag = QSAT;
        else
            mag = (un <<< 16) / ud;
        return neg ? -mag : mag;
    endfunction

    function automatic wide_t err_sq(input wide_t p, input logic [15:0] r);
        wide_t d;
        d = p - (wide_t'(r) <<< 12);
        if (d > DIFF_LIM)
            d = DIFF_LIM;
        if (d < -DIFF_LIM)
            d = -DIFF_LIM;
        return d * d;
    endfunction

    function automatic xfer_t transfer(input wide_t m [9],
                                       input logic [15:0] sx, input logic [15:0] sy,
                                       input logic [15:0] dx, input logic [15:0] dy,
                                       output wide_t chi);
        wide_t nu;
        wide_t nv;
        wide_t w;
        wide_t d2;
        nu  = m[0] * wide_t'(sx) + m[1] * wide_t'(sy) + m[2] * 16;
        nv  = m[3] * wide_t'(sx) + m[4] * wide_t'(sy) + m[5] * 16;
        w   = m[6] * wide_t'(sx) + m[7] * wide_t'(sy) + m[8] * 16;
        chi = 0;
        if (w == 0)
            return XF_DEGEN;
        d2  = err_sq(quot_q16(nu, w), dx) + err_sq(quot_q16(nv, w), dy);
        chi = (d2 * wide_t'(hreg[REG_INV][23:0])) >>> 32;
        return (chi <= wide_t'(CHI_THR)) ? XF_PASS : XF_FAIL;
    endfunction

    function automatic void credit(input wide_t chi);
        wide_t sum;
        sum = wide_t'(score_acc) + wide_t'(CHI_THR) - chi;
        score_acc = (sum > wide_t'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
    endfunction

    function automatic verdict_t score_match(input logic fos, input logic [63:0] pt);
        verdict_t v;
        wide_t    chi;
        xfer_t    r;
        v = '0;
        if (fos)
            score_acc = '0;
        r = transfer(hmat, pt[15:0], pt[31:16], pt[47:32], pt[63:48], chi);
        if (r == XF_DEGEN) begin
            v.degen = 1'b1;
        end else if (r == XF_PASS) begin
            credit(chi);
            r = transfer(adjm, pt[47:32], pt[63:48], pt[15:0], pt[31:16], chi);
            if (r == XF_DEGEN) begin
                v.degen = 1'b1;
            end else if (r == XF_PASS) begin
                credit(chi);
                v.inlier = 1'b1;
            end
        end
        v.score = score_acc;
        return v;
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        logic [63:0] v;
        if (!aresetn) begin
            load_defaults();
            score_acc = '0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready && cfg_index <= REG_INV) begin
                v = cfg_data;
                if (cfg_index == REG_LAST)
                    v = v & 64'hffff_ffff;
                else if (cfg_index == REG_INV)
                    v = v & 64'hff_ffff;
                hreg[cfg_index] = v;
                rebuild_adjugate();
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(score_match(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_q.size() == 0) begin
                    report("unexpected result beat", 64'(m_tdata), 64'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tuser[0] !== want.inlier)
                        report("inlier", 64'(m_tuser[0]), 64'(want.inlier));
                    if (m_tuser[1] !== want.degen)
                        report("degenerate", 64'(m_tuser[1]), 64'(want.degen));
                    if (m_tdata[35:0] !== want.score)
                        report("score_total", 64'(m_tdata[35:0]), 64'(want.score));
                    if (m_tdata[39:36] !== 4'd0)
                        report("tdata pad", 64'(m_tdata[39:36]), 64'd0);
                    n_inlier += m_tuser[0];
                    n_degen  += m_tuser[1];
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the homography inlier scorer: point matches built around a
// series of homographies (defaults, affine, singular, zero, all ones, random,
// perspective), with random gaps on the match side and random backpressure on
// the result side. Prediction and comparison live in hisu_checker.
// ---------------------------------------------------------------------------
module tb_top;
    import hisu_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int         N_PHASE  = 10;
    localparam int         PER_PHASE = 185;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [63:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [39:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         cfg_ready;

    int     errors, pending, n_results, n_inlier, n_degen;
    bit     quiet = 1'b0;
    int     stall_left = 0;
    longint hcoef [9];

    homography_inlier_scorer_unit u_top (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    hisu_checker u_checker (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .errors, .pending, .n_results, .n_inlier, .n_degen
    );

    always #4 aclk = ~aclk;

    initial begin
        #40_000_000;
        $display("timeout, %0d results still outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

    // result-side backpressure
    always @(posedge aclk) begin
        int r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (quiet) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                m_tready <= 1'b1;
            end else if (r < 95) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                stall_left = $urandom_range(20, 80);
                m_tready <= 1'b0;
            end
        end
    end

    task automatic idle_gap();
        int r;
        int n;
        r = quiet ? 0 : $urandom_range(0, 99);
        n = (r < 55) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(20, 80);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_match(input bit fos, input logic [15:0] x1, input logic [15:0] y1,
                              input logic [15:0] x2, input logic [15:0] y2);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tuser  <= fos;
        s_tdata  <= {y2, x2, y1, x1};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic load_homography(input int inv);
        drain();
        repeat (250) @(posedge aclk);
        write_reg(REG_PAIR0, {hcoef[1][31:0], hcoef[0][31:0]});
        write_reg(REG_PAIR1, {hcoef[3][31:0], hcoef[2][31:0]});
        write_reg(REG_PAIR2, {hcoef[5][31:0], hcoef[4][31:0]});
        write_reg(REG_PAIR3, {hcoef[7][31:0], hcoef[6][31:0]});
        write_reg(REG_LAST, {32'h0, hcoef[8][31:0]});
        write_reg(REG_INV, 64'(inv));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // image-2 coordinate in Q.4 under the affine part of the homography
    function automatic logic [15:0] affine_q4(input longint a, input longint b, input longint c,
                                              input longint x, input longint y, input int noise);
        longint v;
        v = ((a * x + b * y + c * 16) >>> 20) + noise;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    task automatic random_match();
        logic [15:0] x1, y1;
        int          r, span, nx, ny;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            send_match($urandom_range(0, 15) == 0, $urandom, $urandom, $urandom, $urandom);
        end else begin
            x1   = $urandom;
            y1   = $urandom;
            span = (r < 75) ? 24 : (r < 92) ? 80 : 2000;
            nx   = $urandom_range(0, 2 * span) - span;
            ny   = $urandom_range(0, 2 * span) - span;
            send_match($urandom_range(0, 15) == 0, x1, y1,
                       affine_q4(hcoef[0], hcoef[1], hcoef[2], x1, y1, nx),
                       affine_q4(hcoef[3], hcoef[4], hcoef[5], x1, y1, ny));
        end
    endtask

    function automatic longint one_q20(input int num, input int den);
        return (longint'(num) <<< 20) / den;
    endfunction

    task automatic random_affine();
        hcoef[0] = one_q20($urandom_range(512, 2048), 1024) + $urandom_range(0, 4095) - 2048;
        hcoef[1] = longint'($urandom_range(0, 131072)) - 65536;
        hcoef[2] = (longint'($urandom_range(0, 400)) - 200) <<< 20;
        hcoef[3] = longint'($urandom_range(0, 131072)) - 65536;
        hcoef[4] = one_q20($urandom_range(512, 2048), 1024);
        hcoef[5] = (longint'($urandom_range(0, 400)) - 200) <<< 20;
        hcoef[6] = 0;
        hcoef[7] = 0;
        hcoef[8] = 1 <<< 20;
    endtask

    initial begin
        int inv;
        for (int i = 0; i < 9; i++)
            hcoef[i] = (i == 0 || i == 1 || i == 4 || i == 8) ? (1 <<< 20) : 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: h00 = h01 = h11 = h22 = 1.0
        send_match(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_match(1'b0, 16'h0010, 16'h0020, 16'h0030, 16'h0020);
        send_match(1'b0, 16'h0010, 16'h0020, 16'h0040, 16'h0020);
        send_match(1'b0, 16'h0010, 16'h0020, 16'h0050, 16'h0030);
        send_match(1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_match(1'b0, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
        send_match(1'b0, 16'h0000, 16'hffff, 16'hffff, 16'hffff);
        send_match(1'b0, 16'hffff, 16'h0000, 16'h0000, 16'hffff);
        send_match(1'b1, 16'h1234, 16'h0100, 16'h1334, 16'h0100);
        send_match(1'b0, 16'h5555, 16'haaaa, 16'hffff, 16'haaaa);
        send_match(1'b0, 16'haaaa, 16'h5555, 16'h0000, 16'h5555);

        for (int p = 0; p < N_PHASE; p++) begin
            quiet = (p == 4 || p == 9);
            inv   = $urandom_range(16384, 262144);
            case (p)
                0: ;
                2: begin
                    // quarter scale: forward error small, back error four times larger
                    for (int i = 0; i < 9; i++)
                        hcoef[i] = 0;
                    hcoef[0] = 1 <<< 18;
                    hcoef[4] = 1 <<< 18;
                    hcoef[8] = 1 <<< 20;
                    load_homography(32'h10000);
                    send_match(1'b1, 16'h0400, 16'h0400, 16'h0110, 16'h0100);
                end
                3: begin
                    // rank one: back projection has a zero denominator
                    for (int i = 0; i < 9; i++)
                        hcoef[i] = (i == 0 || i == 1 || i == 3 || i == 4 || i == 8) ?
                                   (1 <<< 20) : 0;
                    load_homography(32'h10000);
                    send_match(1'b1, 16'h0100, 16'h0200, 16'h0300, 16'h0300);
                end
                4: begin
                    for (int i = 0; i < 9; i++)
                        hcoef[i] = 0;
                    load_homography(32'hff_ffff);
                end
                5: begin
                    for (int i = 0; i < 9; i++)
                        hcoef[i] = -1;
                    load_homography(32'hff_ffff);
                    send_match(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                end
                6: begin
                    for (int i = 0; i < 9; i++)
                        hcoef[i] = longint'(int'($urandom));
                    load_homography($urandom_range(0, 32'hff_ffff));
                    write_reg(REG_NONE, {$urandom, $urandom});
                    cfg_valid <= 1'b0;
                    @(posedge aclk);
                end
                7: begin
                    random_affine();
                    hcoef[6] = longint'($urandom_range(0, 64)) - 32;
                    hcoef[7] = longint'($urandom_range(0, 64)) - 32;
                    load_homography(inv);
                end
                8: begin
                    random_affine();
                    load_homography(0);
                end
                default: begin
                    random_affine();
                    load_homography(inv);
                end
            endcase
            for (int k = 0; k < PER_PHASE; k++) begin
                if (p == 1 && k == 60)
                    drain();
                random_match();
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("%0d matches scored under %0d homography settings", n_results, N_PHASE);
        $display("%0d inliers, %0d degenerate", n_inlier, n_degen);
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
